FILE: rtl/rrm_pkg.sv
`timescale 1ns / 1ps

package rrm_pkg;

  // fixed field widths of the item streams
  localparam int ARCH_REG_W = 6;
  localparam int PHYS_REG_W = 5;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 8;

  // number of distinct codes an arch_reg field can carry
  localparam int ARCH_CODES = 1 << ARCH_REG_W;

  // width of the widened physical index that the result is taken from
  localparam int PHYS_EXT_W = 9;

endpackage

FILE: rtl/register_rename_map_core.sv
`timescale 1ns / 1ps

// Register rename map: every input item names an architected register (in_tdata) and
// whether the access writes it (in_tuser). The result item carries the physical register
// the access uses (out_tdata) and an exhaustion flag (out_tuser). Unmapped registers take
// the next free physical register first; a write then installs a further free register
// for later accesses while this access still reports the old one. Physical registers are
// handed out in ascending order from 0 and never returned. When the free list cannot
// cover an access, the result is register 0 with the flag set and nothing changes.
// Throughput is one item per cycle unless out_tready stalls the output. The map table is
// a synchronous memory read when an item is accepted and updated when the item leaves
// the second stage; a write to the entry the following item reads is forwarded around
// the memory. The mapped flags are flip-flops, so reset needs no clearing pass.
module register_rename_map_core
  import rrm_pkg::*;
#(
  parameter int ARCH_REGS = 64,
  parameter int PHYS_REGS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input items
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [5:0] arch_reg, [7:6] zero
  input  logic                  in_tuser,   // [0] write access flag
  // result items
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [4:0] phys_reg, [7:5] zero
  output logic                  out_tuser   // [0] exhausted
);

  localparam int AW = $clog2(ARCH_REGS);
  localparam int PW = $clog2(PHYS_REGS);
  localparam int CW = $clog2(PHYS_REGS + 1);

  // arch_reg wrapped into the table range, one entry per input code
  function automatic logic [ARCH_CODES*AW-1:0] build_wrap();
    logic [ARCH_CODES*AW-1:0] t;
    int r;
    t = '0;
    r = 0;
    for (int i = 0; i < ARCH_CODES; i++) begin
      t[i*AW +: AW] = AW'(r);
      r = r + 1;
      if (r == ARCH_REGS) begin
        r = 0;
      end
    end
    return t;
  endfunction

  localparam logic [ARCH_CODES*AW-1:0] WRAP_TBL = build_wrap();

  // map table storage and mapped flags
  logic [PW-1:0]        map_mem [ARCH_REGS];
  logic [ARCH_REGS-1:0] map_vld_r;
  logic [ARCH_REGS-1:0] map_vld_nxt;

  // second stage: item whose map entry has been read
  logic          s1_vld_r, s1_vld_nxt;
  logic [AW-1:0] s1_idx_r;
  logic          s1_wr_r;
  logic [PW-1:0] rd_data_r;
  logic          fwd_hit_r;
  logic [PW-1:0] fwd_data_r;

  // free list as head and count
  logic [PW-1:0] head_r, head_nxt;
  logic [CW-1:0] free_cnt_r, free_cnt_nxt;

  // output register
  logic                  out_vld_r, out_vld_nxt;
  logic [PHYS_REG_W-1:0] out_phys_r;
  logic                  out_exh_r;

  logic          in_acc;
  logic [AW-1:0] in_idx;
  logic          s1_adv;
  logic          s1_mapped;
  logic [PW-1:0] s1_cur;
  logic [1:0]    s1_need;
  logic          s1_exh;
  logic          map_we;
  logic [PW-1:0] map_wdata;
  logic [PW-1:0] res_phys;
  logic [PW:0]   head_sum;
  logic [PHYS_EXT_W-1:0] res_ext;

  // handshake and stage advance
  assign s1_adv    = !out_vld_r || out_tready;
  assign in_tready = !s1_vld_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;
  assign in_idx    = WRAP_TBL[in_tdata[ARCH_REG_W-1:0]*AW +: AW];

  // rename decision for the item in the second stage
  always_comb begin
    s1_mapped = map_vld_r[s1_idx_r];
    s1_cur    = fwd_hit_r ? fwd_data_r : rd_data_r;
    s1_need   = {1'b0, !s1_mapped} + {1'b0, s1_wr_r};
    s1_exh    = free_cnt_r < CW'(s1_need);
    res_phys  = s1_mapped ? s1_cur : head_r;
    // second pop follows the first when both are needed
    if (s1_wr_r) begin
      map_wdata = s1_mapped ? head_r : PW'(head_r + PW'(1));
    end else begin
      map_wdata = head_r;
    end
    map_we   = s1_vld_r && s1_adv && !s1_exh && (s1_wr_r || !s1_mapped);
    head_sum = {1'b0, head_r} + (PW + 1)'(s1_need);
    res_ext  = PHYS_EXT_W'(res_phys);
  end

  // next state
  always_comb begin
    map_vld_nxt  = map_vld_r;
    head_nxt     = head_r;
    free_cnt_nxt = free_cnt_r;
    if (map_we) begin
      map_vld_nxt[s1_idx_r] = 1'b1;
      free_cnt_nxt = free_cnt_r - CW'(s1_need);
      if (head_sum >= (PW + 1)'(PHYS_REGS)) begin
        head_nxt = PW'(head_sum - (PW + 1)'(PHYS_REGS));
      end else begin
        head_nxt = head_sum[PW-1:0];
      end
    end
    s1_vld_nxt  = in_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_vld_r);
    out_vld_nxt = s1_adv ? s1_vld_r : out_vld_r;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_vld_r  <= '0;
      head_r     <= '0;
      free_cnt_r <= CW'(PHYS_REGS);
      s1_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
      fwd_hit_r  <= 1'b0;
    end else begin
      map_vld_r  <= map_vld_nxt;
      head_r     <= head_nxt;
      free_cnt_r <= free_cnt_nxt;
      s1_vld_r   <= s1_vld_nxt;
      out_vld_r  <= out_vld_nxt;
      if (in_acc) begin
        fwd_hit_r <= map_we && (s1_idx_r == in_idx);
      end else if (s1_adv) begin
        // second stage empties, nothing left to forward to
        fwd_hit_r <= 1'b0;
      end
    end
  end

  // map table memory: read on accept, write back from the second stage
  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[s1_idx_r] <= map_wdata;
    end
    if (in_acc) begin
      rd_data_r <= map_mem[in_idx];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_idx_r   <= in_idx;
      s1_wr_r    <= in_tuser;
      fwd_data_r <= map_wdata;
    end
    if (s1_vld_r && s1_adv) begin
      out_phys_r <= s1_exh ? '0 : res_ext[PHYS_REG_W-1:0];
      out_exh_r  <= s1_exh;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = OUT_DATA_W'(out_phys_r);
  assign out_tuser  = out_exh_r;

`ifndef SYNTHESIS
  // free count never exceeds the pool
  assert property (@(posedge clk) disable iff (!rst_n)
    32'(free_cnt_r) <= PHYS_REGS)
    else $error("free count above pool size");

  // head and count stay consistent while registers remain
  assert property (@(posedge clk) disable iff (!rst_n)
    (free_cnt_r == '0) || (32'(head_r) + 32'(free_cnt_r) == PHYS_REGS))
    else $error("free list head and count disagree");

  // an exhausted result reports register zero
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata == '0))
    else $error("exhausted item carries a register");

  // forwarding only applies to an item held in the second stage
  assert property (@(posedge clk) disable iff (!rst_n)
    fwd_hit_r |-> s1_vld_r)
    else $error("forward flag without item");

  // an exhausted item leaves the free count untouched
  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && s1_adv && s1_exh) |=> $stable(free_cnt_r))
    else $error("state changed on exhaustion");
`endif

endmodule
